### design/bf_loop_replay_interpreter_defines.svh
// Assertion helpers included by the top-level interpreter file.
`ifndef BF_LOOP_REPLAY_INTERPRETER_DEFINES_SVH
`define BF_LOOP_REPLAY_INTERPRETER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFLR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BFLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bflr_pkg.sv
`default_nettype none
package bflr_pkg;
	localparam int TAPE_AW    = 16;
	localparam int TAPE_DEPTH = 1 << TAPE_AW;
	localparam int BUF_DEPTH  = 1024;
	localparam int BUF_AW     = $clog2(BUF_DEPTH);
	localparam int BUF_LW     = BUF_AW + 1;
	localparam int STK_DEPTH  = 64;
	localparam int STK_AW     = $clog2(STK_DEPTH);
	localparam int STK_CW     = STK_AW + 1;
	localparam int SKIP_W     = 16;
	localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

	localparam logic [1:0] CMD_SYM  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [2:0] OP_LEFT  = 3'd0;
	localparam logic [2:0] OP_RIGHT = 3'd1;
	localparam logic [2:0] OP_INC   = 3'd2;
	localparam logic [2:0] OP_DEC   = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_WRITE = 3'd5;
	localparam logic [2:0] OP_OPEN  = 3'd6;
	localparam logic [2:0] OP_CLOSE = 3'd7;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BUF_FULL  = 3'd1;
	localparam logic [2:0] ERR_STK_FULL  = 3'd2;
	localparam logic [2:0] ERR_UNMATCHED = 3'd3;
	localparam logic [2:0] ERR_KIND      = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] opcode;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] want;
		logic       out_valid;
		logic [7:0] out_byte;
		logic [2:0] error;
	} res_item_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_stat_t;
endpackage
`default_nettype wire

### design/bflr_ram.sv
`default_nettype none
module bflr_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### design/bflr_front.sv
`default_nettype none
module bflr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bflr_pkg::in_item_t in_item,
	output logic                    q_valid,
	output bflr_pkg::in_item_t      q_item,
	input  wire logic               q_pop
);
	import bflr_pkg::*;

	in_item_t   slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

### design/bflr_back.sv
`default_nettype none
module bflr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire bflr_pkg::in_item_t q_item,
	output logic                    q_pop,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output bflr_pkg::res_item_t     res_item,
	output bflr_pkg::back_stat_t    stat
);
	import bflr_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} back_state_t;

	back_state_t         state_q;
	logic [TAPE_AW-1:0]  clr_q;
	in_item_t            item_s1;
	logic [TAPE_AW-1:0]  ptr_q, n_ptr;
	logic [BUF_LW-1:0]   bl_q, n_bl;
	logic [BUF_LW-1:0]   rp_q, n_rp;
	logic                buf_q, n_buf;
	logic [STK_CW-1:0]   sc_q, n_sc;
	logic [SKIP_W-1:0]   skip_q, n_skip;
	logic [1:0]          want_q, n_want;
	logic                res_valid_q;
	res_item_t           res_q;

	logic [7:0]          cur_cell;
	logic [2:0]          bop;
	logic [BUF_AW-1:0]   top;
	logic [STK_CW-1:0]   sc_m1;
	logic                exec_fire;
	logic                clearing;
	logic                from_buf, append, do_fw, new_loop;
	logic [2:0]          op, err;
	logic                ov;
	logic [7:0]          ob;
	logic                tape_we, buf_we, stk_we;
	logic [7:0]          tape_wd;
	logic [BUF_AW-1:0]   buf_wa;

	assign clearing  = (state_q == ST_CLEAR);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign exec_fire = (state_q == ST_EXEC) && (!res_valid_q || res_ready);
	assign sc_m1     = sc_q - 1'b1;

	bflr_ram #(.W(8), .D(TAPE_DEPTH)) u_tape (
		.clk   (clk),
		.we    (clearing || (exec_fire && tape_we)),
		.waddr (clearing ? clr_q : ptr_q),
		.wdata (clearing ? 8'd0 : tape_wd),
		.raddr (ptr_q),
		.rdata (cur_cell)
	);

	bflr_ram #(.W(3), .D(BUF_DEPTH)) u_buf (
		.clk   (clk),
		.we    (exec_fire && buf_we),
		.waddr (buf_wa),
		.wdata (op),
		.raddr (rp_q[BUF_AW-1:0]),
		.rdata (bop)
	);

	bflr_ram #(.W(BUF_AW), .D(STK_DEPTH)) u_stk (
		.clk   (clk),
		.we    (exec_fire && stk_we),
		.waddr (new_loop ? '0 : sc_q[STK_AW-1:0]),
		.wdata (new_loop ? '0 : rp_q[BUF_AW-1:0]),
		.raddr (sc_m1[STK_AW-1:0]),
		.rdata (top)
	);

	always_comb begin
		from_buf = (item_s1.command == CMD_TICK);
		append   = !from_buf && buf_q;
		op       = from_buf ? bop : item_s1.opcode;
		n_ptr    = ptr_q;
		n_bl     = bl_q;
		n_rp     = rp_q;
		n_buf    = buf_q;
		n_sc     = sc_q;
		n_skip   = skip_q;
		n_want   = want_q;
		err      = ERR_NONE;
		ov       = 1'b0;
		ob       = 8'd0;
		tape_we  = 1'b0;
		tape_wd  = cur_cell;
		buf_we   = 1'b0;
		buf_wa   = bl_q[BUF_AW-1:0];
		stk_we   = 1'b0;
		new_loop = 1'b0;
		do_fw    = 1'b0;
		if (item_s1.command != want_q) begin
			err = ERR_KIND;
		end else if (item_s1.command == CMD_BYTE) begin
			tape_we = 1'b1;
			tape_wd = item_s1.in_byte;
			do_fw   = 1'b1;
		end else if (from_buf && (rp_q >= bl_q)) begin
			do_fw = 1'b1;
		end else if (append && (bl_q >= BUF_LW'(BUF_DEPTH))) begin
			err = ERR_BUF_FULL;
		end else if ((skip_q == '0) && (op == OP_OPEN) && (cur_cell != 8'd0)
				&& (sc_q >= STK_CW'(STK_DEPTH))) begin
			err = ERR_STK_FULL;
		end else begin
			if (append) begin
				buf_we = 1'b1;
				n_bl   = bl_q + 1'b1;
			end
			if (buf_q) begin
				n_rp = rp_q + 1'b1;
			end
			n_want = CMD_SYM;
			do_fw  = 1'b1;
			if (skip_q != '0) begin
				if (op == OP_OPEN) begin
					if (skip_q != SKIP_MAX) begin
						n_skip = skip_q + 1'b1;
					end
				end else if (op == OP_CLOSE) begin
					n_skip = skip_q - 1'b1;
				end
			end else begin
				case (op)
					OP_LEFT: begin
						n_ptr = ptr_q - 1'b1;
					end
					OP_RIGHT: begin
						n_ptr = ptr_q + 1'b1;
					end
					OP_INC: begin
						tape_we = 1'b1;
						tape_wd = cur_cell + 8'd1;
					end
					OP_DEC: begin
						tape_we = 1'b1;
						tape_wd = cur_cell - 8'd1;
					end
					OP_READ: begin
						n_want = CMD_BYTE;
						do_fw  = 1'b0;
					end
					OP_WRITE: begin
						ov = 1'b1;
						ob = cur_cell;
					end
					OP_OPEN: begin
						if (cur_cell == 8'd0) begin
							n_skip = SKIP_W'(1);
						end else if (!buf_q) begin
							// outermost taken loop: start recording with this symbol
							buf_we   = 1'b1;
							buf_wa   = '0;
							n_bl     = BUF_LW'(1);
							n_rp     = BUF_LW'(1);
							n_buf    = 1'b1;
							stk_we   = 1'b1;
							new_loop = 1'b1;
							n_sc     = STK_CW'(1);
						end else begin
							stk_we = 1'b1;
							n_sc   = sc_q + 1'b1;
						end
					end
					default: begin
						if (sc_q == '0) begin
							err = ERR_UNMATCHED;
						end else begin
							n_sc = sc_m1;
							if (cur_cell != 8'd0) begin
								n_rp = {1'b0, top};
							end else if (sc_m1 == '0) begin
								n_buf = 1'b0;
								n_bl  = '0;
								n_rp  = '0;
							end
						end
					end
				endcase
			end
		end
		if (do_fw) begin
			n_want = (n_buf && (n_rp < n_bl)) ? CMD_TICK : CMD_SYM;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
		if (exec_fire) begin
			res_q.want      <= n_want;
			res_q.out_valid <= ov;
			res_q.out_byte  <= ob;
			res_q.error     <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			bl_q        <= '0;
			rp_q        <= '0;
			buf_q       <= 1'b0;
			sc_q        <= '0;
			skip_q      <= '0;
			want_q      <= CMD_SYM;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
						ptr_q   <= n_ptr;
						bl_q    <= n_bl;
						rp_q    <= n_rp;
						buf_q   <= n_buf;
						sc_q    <= n_sc;
						skip_q  <= n_skip;
						want_q  <= n_want;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_fire) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign res_item      = res_q;
	assign stat.clearing = clearing;
	assign stat.pop      = q_pop;
endmodule
`default_nettype wire

### design/bf_loop_replay_interpreter.sv
// Tape-language interpreter, one step per transfer. After reset the tape (65536 cells)
// is zeroed by a clearing pass; items are queued (two deep) but not executed until it
// ends. Each item is then taken in the idle state, in which the current tape cell, the
// recorded loop symbol and the loop stack top are read from their synchronous RAMs,
// and executed and written back in the execute state. The result register lets the
// next item be taken and read while a result waits, but not executed until it is taken.
`default_nettype none
`include "bf_loop_replay_interpreter_defines.svh"
module bf_loop_replay_interpreter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire bflr_pkg::in_item_t  in_item,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output bflr_pkg::res_item_t      res_item
);
	import bflr_pkg::*;

	logic       q_valid;
	in_item_t   q_item;
	logic       q_pop;
	back_stat_t stat;

	bflr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	bflr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.stat      (stat)
	);

	`BFLR_ASSERT_NOW(a_no_pop_clearing, stat.clearing, !stat.pop, "item taken during clear")
	`BFLR_ASSERT_NOW(a_err_range, res_valid, res_item.error <= ERR_KIND, "bad error code")
	`BFLR_ASSERT_NOW(a_write_no_err, res_valid && res_item.out_valid,
		res_item.error == ERR_NONE, "output byte with error")
	`BFLR_ASSERT_NEXT(a_pop_then_busy, stat.pop, !stat.pop, "back-to-back pop")
endmodule
`default_nettype wire

### bench/bf_loop_replay_interpreter_test.sv
`timescale 1ns / 1ps
`default_nettype none
module bf_loop_replay_interpreter_test;
	import bflr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_item;

	bf_loop_replay_interpreter DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	logic [7:0] cells [TAPE_DEPTH];
	logic [TAPE_AW-1:0] ptr_m;
	logic [2:0] rec_ops [BUF_DEPTH];
	int unsigned rec_len, rep_pos, stk_cnt, skip_cnt;
	logic recording;
	int unsigned stk [STK_DEPTH];
	logic [1:0] want_m;

	in_item_t pending_items [$];
	res_item_t expected_results [$];
	int errors = 0;
	longint cycle = 0;
	logic calm = 1'b0;
	// transfer seen at the last rising edge
	logic in_ready_s = 1'b0;

	function automatic logic [1:0] fetch_kind();
		return (recording && rep_pos < rec_len) ? CMD_TICK : CMD_SYM;
	endfunction

	function automatic res_item_t interpret(in_item_t it);
		res_item_t r;
		logic [2:0] op;
		logic [7:0] c;
		logic from_buf, append;
		r = '0;
		op = it.opcode;
		if (it.command != want_m) begin
			r.error = ERR_KIND;
			r.want = want_m;
			return r;
		end
		if (it.command == CMD_BYTE) begin
			cells[ptr_m] = it.in_byte;
			want_m = fetch_kind();
			r.want = want_m;
			return r;
		end
		from_buf = (it.command == CMD_TICK);
		if (from_buf) begin
			if (rep_pos >= BUF_DEPTH || rep_pos >= rec_len) begin
				want_m = fetch_kind();
				r.want = want_m;
				return r;
			end
			op = rec_ops[rep_pos];
		end
		append = !from_buf && recording;
		if (append && rec_len >= BUF_DEPTH) begin
			r.error = ERR_BUF_FULL;
			r.want = want_m;
			return r;
		end
		c = cells[ptr_m];
		if (skip_cnt == 0 && op == OP_OPEN && c != 0 && stk_cnt >= STK_DEPTH) begin
			r.error = ERR_STK_FULL;
			r.want = want_m;
			return r;
		end
		if (append) begin
			rec_ops[rec_len] = op;
			rec_len++;
		end
		if (recording) rep_pos++;
		want_m = CMD_SYM;
		if (skip_cnt > 0) begin
			if (op == OP_OPEN) begin
				if (skip_cnt < 65535) skip_cnt++;
			end else if (op == OP_CLOSE) begin
				skip_cnt--;
			end
		end else begin
			case (op)
				OP_LEFT: ptr_m = ptr_m - 1'b1;
				OP_RIGHT: ptr_m = ptr_m + 1'b1;
				OP_INC: cells[ptr_m] = c + 8'd1;
				OP_DEC: cells[ptr_m] = c - 8'd1;
				OP_READ: want_m = CMD_BYTE;
				OP_WRITE: begin
					r.out_valid = 1'b1;
					r.out_byte = c;
				end
				OP_OPEN: begin
					if (c == 0) begin
						skip_cnt = 1;
					end else if (!recording) begin
						rec_ops[0] = OP_OPEN;
						rec_len = 1;
						rep_pos = 1;
						recording = 1'b1;
						stk[0] = 0;
						stk_cnt = 1;
					end else begin
						stk[stk_cnt % STK_DEPTH] = rep_pos - 1;
						stk_cnt++;
					end
				end
				default: begin
					if (stk_cnt == 0) begin
						r.error = ERR_UNMATCHED;
					end else begin
						stk_cnt--;
						if (c != 0) begin
							rep_pos = stk[stk_cnt % STK_DEPTH];
						end else if (stk_cnt == 0) begin
							recording = 1'b0;
							rec_len = 0;
							rep_pos = 0;
						end
					end
				end
			endcase
		end
		if (want_m != CMD_BYTE) want_m = fetch_kind();
		r.want = want_m;
		return r;
	endfunction

	// Stimulus generation runs against a shadow predictor so items match what is wanted.
	// The real prediction is redone at transfer time from the same state sequence.
	function automatic in_item_t sym(logic [2:0] op);
		in_item_t it;
		it.command = CMD_SYM;
		it.opcode = op;
		it.in_byte = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t kind_item(logic [1:0] k, logic [2:0] op, logic [7:0] b);
		in_item_t it;
		it.command = k;
		it.opcode = op;
		it.in_byte = b;
		return it;
	endfunction

	// generated items are first applied to the model to learn the next wanted kind,
	// then the model is reset before traffic starts
	int gen_count = 0;
	task automatic push_item(in_item_t it);
		res_item_t dummy;
		dummy = interpret(it);
		pending_items = {pending_items, it};
		gen_count++;
	endtask

	// feed input bytes and replay ticks until a program symbol is wanted
	task automatic flush_wanted();
		while (want_m != CMD_SYM) push_item(kind_item(want_m, 3'($urandom), 8'($urandom)));
	endtask

	task automatic push_op(logic [2:0] op);
		flush_wanted();
		push_item(sym(op));
	endtask

	// an item of a kind other than the wanted one
	task automatic push_noise();
		logic [1:0] k;
		k = want_m + 2'($urandom_range(1, 3));
		push_item(kind_item(k, 3'($urandom), 8'($urandom)));
	endtask

	task automatic model_reset();
		foreach (cells[i]) cells[i] = 8'd0;
		ptr_m = '0;
		rec_len = 0;
		rep_pos = 0;
		recording = 1'b0;
		stk_cnt = 0;
		skip_cnt = 0;
		want_m = CMD_SYM;
	endtask

	initial begin : stimulus
		int loops;
		int sel;
		int steps;
		int k;
		model_reset();
		// directed
		push_item(kind_item(CMD_TICK, OP_INC, 8'hff));
		push_item(kind_item(2'd3, OP_CLOSE, 8'h00));
		push_item(kind_item(CMD_BYTE, OP_READ, 8'h55));
		push_item(sym(OP_CLOSE));
		push_item(sym(OP_WRITE));
		push_item(sym(OP_DEC));
		push_item(sym(OP_WRITE));
		push_item(sym(OP_LEFT));
		push_item(sym(OP_READ));
		push_item(kind_item(CMD_SYM, OP_INC, 8'h00));
		push_item(kind_item(CMD_BYTE, OP_INC, 8'hff));
		push_item(sym(OP_RIGHT));
		push_item(sym(OP_RIGHT));
		push_item(sym(OP_OPEN));
		push_item(sym(OP_OPEN));
		push_item(sym(OP_INC));
		push_item(sym(OP_CLOSE));
		push_item(sym(OP_CLOSE));
		push_item(sym(OP_LEFT));
		push_item(sym(OP_READ));
		push_item(kind_item(CMD_BYTE, 3'd0, 8'h00));
		push_item(sym(OP_INC));
		push_item(sym(OP_INC));
		// loop stack overflow: nested opens on a nonzero cell
		for (int i = 0; i < STK_DEPTH + 3; i++) push_op(OP_OPEN);
		// drain: decrement to zero then close everything
		while (recording) push_op(cells[ptr_m] != 0 ? OP_DEC : OP_CLOSE);
		// random: small well-formed loops, skipped loops, stray ends and noise
		while (gen_count < 1850 - BUF_DEPTH - 12) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				push_noise();
			end else if (sel < 30) begin
				// counted loop on a zero cell with a nested loop two cells over
				flush_wanted();
				steps = 0;
				while ((cells[ptr_m] != 8'd0 || cells[TAPE_AW'(ptr_m + 2)] != 8'd0)
						&& steps < 8) begin
					push_op(OP_RIGHT);
					steps++;
				end
				if (cells[ptr_m] == 8'd0 && cells[TAPE_AW'(ptr_m + 2)] == 8'd0) begin
					loops = $urandom_range(1, 3);
					for (int i = 0; i < loops; i++) push_op(OP_INC);
					push_op(OP_OPEN);
					push_op(OP_RIGHT);
					k = $urandom_range(0, 3);
					for (int i = 0; i < k; i++) push_op(3'($urandom_range(2, 5)));
					push_op(OP_RIGHT);
					k = $urandom_range(1, 2);
					for (int i = 0; i < k; i++) push_op(OP_INC);
					push_op(OP_OPEN);
					push_op(OP_DEC);
					push_op(OP_CLOSE);
					push_op(OP_LEFT);
					push_op(OP_LEFT);
					push_op(OP_DEC);
					push_op(OP_CLOSE);
					flush_wanted();
				end
			end else if (sel < 40) begin
				// loop start on a zero cell: the body is skipped
				flush_wanted();
				if (cells[ptr_m] == 8'd0) begin
					push_op(OP_OPEN);
					k = $urandom_range(0, 3);
					for (int i = 0; i < k; i++) begin
						if ($urandom_range(0, 3) == 0) begin
							push_op(OP_OPEN);
							push_op(OP_CLOSE);
						end else begin
							push_op(3'($urandom_range(0, 5)));
						end
					end
					push_op(OP_CLOSE);
				end else begin
					push_op(OP_WRITE);
				end
			end else if (sel < 45) begin
				push_op(OP_CLOSE);
			end else begin
				push_op(3'($urandom_range(0, 5)));
			end
		end
		// buffer full last: the loop can never be left once the buffer is full
		flush_wanted();
		if (cells[ptr_m] == 8'd0) push_op(OP_INC);
		push_op(OP_OPEN);
		for (int i = 0; i < BUF_DEPTH + 4; i++) push_op((i % 2) != 0 ? OP_RIGHT : OP_LEFT);
		push_op(OP_DEC);
		push_op(OP_CLOSE);
		push_noise();
		model_reset();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// idle pattern: a calm stretch with no gaps in the middle of the run
	always @(posedge clk) begin
		cycle <= cycle + 1;
		calm <= (cycle > 66500 && cycle < 68000);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			res_ready <= 1'b0;
		end else begin
			if (!in_valid || in_ready_s) begin
				if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			res_ready <= calm || ($urandom_range(0, 99) >= 23);
		end
	end

	always @(posedge clk) begin
		res_item_t exp_r;
		in_ready_s <= 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_ready_s <= 1'b1;
				expected_results = {expected_results, interpret(in_item)};
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %p", $time, res_item);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (res_item !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, res_item);
						errors++;
					end
				end
			end
		end
	end

	initial begin : finish_run
		wait (arst_n);
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) begin
			@(posedge clk);
			if (cycle > 1000000) begin
				$display("bf_loop_replay_interpreter regression: fail");
				$finish;
			end
		end
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("bf_loop_replay_interpreter regression: pass");
		else
			$display("bf_loop_replay_interpreter regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
